// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the igniter sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PIS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PIS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pis_pkg.sv =====
// Types and constants of the igniter sequencer.
package pis_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_MODE    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DELAY   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_FIRE    = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_CHARGE  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_OPEN    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_CLOSED  = 3'd5;

	localparam logic [1:0] MODE_DUAL   = 2'd0;
	localparam logic [1:0] MODE_APOGEE = 2'd1;
	localparam logic [1:0] MODE_MAIN   = 2'd2;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_REQ    = 2'd1;
	localparam logic [1:0] FUNC_MANUAL = 2'd2;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_ACTIVE  = 2'd2;
	localparam logic [1:0] ST_OPEN    = 2'd3;

	localparam logic [15:0] FIRE_RESET   = 16'd5;
	localparam logic [15:0] CHARGE_RESET = 16'd200;
	localparam logic signed [15:0] OPEN_RESET   = 16'sd1000;
	localparam logic signed [15:0] CLOSED_RESET = 16'sd7000;

	// position in a channel's phase list
	localparam logic [2:0] POS_DELAY = 3'd0;
	localparam logic [2:0] POS_FIRE1 = 3'd1;
	localparam logic [2:0] POS_GAP   = 3'd2;
	localparam logic [2:0] POS_FIRE2 = 3'd3;
	localparam logic [2:0] POS_POST  = 3'd4;
	localparam logic [2:0] POS_NONE  = 3'd5;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_DELAY  = 7'b0000010,
		PH_SINGLE = 7'b0000100,
		PH_PAIR1  = 7'b0001000,
		PH_GAP    = 7'b0010000,
		PH_PAIR2  = 7'b0100000,
		PH_POST   = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SINGLE,
		KIND_PAIR
	} kind_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        delay_ticks;
		logic [15:0]        fire_ticks;
		logic [15:0]        charge_ticks;
		logic signed [15:0] open_level;
		logic signed [15:0] closed_level;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         func;
		logic               igniter_sel;
		logic signed [15:0] drogue_sense;
		logic signed [15:0] main_sense;
	} item_t;

	typedef struct packed {
		logic       drogue_out;
		logic       main_out;
		logic [1:0] drogue_status;
		logic [1:0] main_status;
		logic       busy_res;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] count;
		logic        ch;
		logic        manual;
		logic [1:0]  req;
		logic [1:0]  fired;
		logic [1:0]  firing;
	} seq_t;

endpackage

// ===== hw/rtl/pis_cfg_regs.sv =====
// Configuration register file of the igniter sequencer.
module pis_cfg_regs import pis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_DUAL;
			cfg_q.delay_ticks  <= '0;
			cfg_q.fire_ticks   <= FIRE_RESET;
			cfg_q.charge_ticks <= CHARGE_RESET;
			cfg_q.open_level   <= OPEN_RESET;
			cfg_q.closed_level <= CLOSED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   cfg_q.mode         <= cfg_data[1:0];
				CFG_DELAY:  cfg_q.delay_ticks  <= cfg_data;
				CFG_FIRE:   cfg_q.fire_ticks   <= cfg_data;
				CFG_CHARGE: cfg_q.charge_ticks <= cfg_data;
				CFG_OPEN:   cfg_q.open_level   <= $signed(cfg_data);
				CFG_CLOSED: cfg_q.closed_level <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pis_seq_core.sv =====
// Sequence state and its combinational update for one item.
module pis_seq_core import pis_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	seq_t st_q;
	seq_t st_ev;
	seq_t st_l1;
	seq_t st_n;

	function automatic kind_t kind_of(logic [1:0] mode, logic ch);
		kind_t k;
		k = KIND_NONE;
		if (mode == MODE_DUAL)
			k = KIND_SINGLE;
		else if ((mode == MODE_APOGEE && !ch) || (mode == MODE_MAIN && ch))
			k = KIND_PAIR;
		return k;
	endfunction

	// land on the first phase from spos onwards that is available for the kind and has a non-zero length
	function automatic seq_t resolve(seq_t st, logic [2:0] spos, kind_t kind, logic ch,
			logic man, cfg_t c);
		logic [4:0] avail;
		logic [4:0] nz;
		logic [4:0] elig;
		logic       hit;
		logic [2:0] pos;
		logic [1:0] bit_ch;
		seq_t       r;
		r = st;
		bit_ch = ch ? 2'b10 : 2'b01;
		avail = {!man, kind == KIND_PAIR, kind == KIND_PAIR, kind != KIND_NONE, 1'b1};
		nz = {c.charge_ticks != '0, c.fire_ticks != '0, c.charge_ticks != '0,
			c.fire_ticks != '0, c.delay_ticks != '0};
		elig = avail & nz;
		for (int i = 0; i < 5; i++) begin
			if (3'(i) < spos)
				elig[i] = 1'b0;
		end
		hit = 1'b0;
		pos = POS_NONE;
		for (int i = 4; i >= 0; i--) begin
			if (elig[i]) begin
				hit = 1'b1;
				pos = 3'(i);
			end
		end
		r.ch = ch;
		r.manual = hit ? man : 1'b0;
		r.firing = 2'b00;
		if (hit) begin
			case (pos)
				POS_DELAY: begin
					r.phase = PH_DELAY;
					r.count = c.delay_ticks;
				end
				POS_FIRE1: begin
					r.phase = (kind == KIND_SINGLE) ? PH_SINGLE : PH_PAIR1;
					r.count = c.fire_ticks;
					r.firing = bit_ch;
				end
				POS_GAP: begin
					r.phase = PH_GAP;
					r.count = c.charge_ticks;
					r.firing = bit_ch;
				end
				POS_FIRE2: begin
					r.phase = PH_PAIR2;
					r.count = c.fire_ticks;
					r.firing = bit_ch;
				end
				POS_POST: begin
					r.phase = PH_POST;
					r.count = c.charge_ticks;
				end
				default: begin
					r.phase = PH_IDLE;
					r.count = '0;
				end
			endcase
		end else begin
			r.phase = PH_IDLE;
			r.count = '0;
			if (!man)
				r.fired = st.fired | bit_ch;
		end
		return r;
	endfunction

	// start a pending request once idle, drogue first
	function automatic seq_t launch(seq_t st, cfg_t c);
		logic [1:0] pend;
		logic       ch;
		seq_t       r;
		r = st;
		pend = st.req & ~st.fired;
		ch = !pend[0];
		if (st.phase == PH_IDLE && pend != 2'b00)
			r = resolve(st, ch ? POS_FIRE1 : POS_DELAY, kind_of(c.mode, ch), ch, 1'b0, c);
		return r;
	endfunction

	function automatic logic [1:0] status_of(logic active, logic signed [15:0] sense, cfg_t c);
		logic [1:0] s;
		if (active)
			s = ST_ACTIVE;
		else if (sense < c.open_level)
			s = ST_OPEN;
		else if (sense > c.closed_level)
			s = ST_READY;
		else
			s = ST_UNKNOWN;
		return s;
	endfunction

	always_comb begin
		st_ev = st_q;
		case (item.func)
			FUNC_TICK: begin
				if (st_q.phase != PH_IDLE) begin
					if (st_q.count > 16'd1) begin
						st_ev.count = st_q.count - 16'd1;
					end else begin
						case (st_q.phase)
							PH_DELAY: st_ev = resolve(st_q, POS_FIRE1, kind_of(cfg.mode, st_q.ch),
								st_q.ch, st_q.manual, cfg);
							PH_SINGLE: st_ev = resolve(st_q, POS_POST, KIND_SINGLE, st_q.ch,
								st_q.manual, cfg);
							PH_PAIR1: st_ev = resolve(st_q, POS_GAP, KIND_PAIR, st_q.ch,
								st_q.manual, cfg);
							PH_GAP: st_ev = resolve(st_q, POS_FIRE2, KIND_PAIR, st_q.ch,
								st_q.manual, cfg);
							PH_PAIR2: st_ev = resolve(st_q, POS_POST, KIND_PAIR, st_q.ch,
								st_q.manual, cfg);
							PH_POST: st_ev = resolve(st_q, POS_NONE, KIND_PAIR, st_q.ch,
								st_q.manual, cfg);
							default: st_ev = st_q;
						endcase
					end
				end
			end
			FUNC_REQ: begin
				st_ev.req = st_q.req | (item.igniter_sel ? 2'b10 : 2'b01);
			end
			FUNC_MANUAL: begin
				if (st_q.phase == PH_IDLE)
					st_ev = resolve(st_q, POS_FIRE1, kind_of(cfg.mode, item.igniter_sel),
						item.igniter_sel, 1'b1, cfg);
			end
			default: ;
		endcase
		st_l1 = launch(st_ev, cfg);
		st_n = launch(st_l1, cfg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase  <= PH_IDLE;
			st_q.count  <= '0;
			st_q.ch     <= 1'b0;
			st_q.manual <= 1'b0;
			st_q.req    <= 2'b00;
			st_q.fired  <= 2'b00;
			st_q.firing <= 2'b00;
		end else if (step) begin
			st_q <= st_n;
		end
	end

	always_comb begin
		res.drogue_out = (st_n.phase == PH_PAIR1) || (st_n.phase == PH_SINGLE && !st_n.ch);
		res.main_out = (st_n.phase == PH_PAIR2) || (st_n.phase == PH_SINGLE && st_n.ch);
		res.drogue_status = status_of(st_n.firing[0] || (st_n.req[0] && !st_n.fired[0]),
			item.drogue_sense, cfg);
		res.main_status = status_of(st_n.firing[1] || (st_n.req[1] && !st_n.fired[1]),
			item.main_sense, cfg);
		res.busy_res = st_n.phase != PH_IDLE;
	end

endmodule

// ===== hw/rtl/pyro_igniter_sequencer.sv =====
// Top level of the two-channel igniter sequencer.
// One item is accepted per clock while s_tready is high; it is held in an input register, and
// the combinational sequence update then writes its result into the result register. The stream
// sustains one item per clock whenever the result side takes every result. Configuration
// writes are registered and must be made while no item is in flight.
`include "assert_macros.svh"
module pyro_igniter_sequencer import pis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // drogue_sense[15:0], main_sense[31:16]
	input  logic [2:0]          s_tuser,   // func[1:0], igniter_sel[2]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // drogue_out[0], main_out[1], drogue_status[3:2],
	                                       // main_status[5:4], busy_res[6], zero[7]
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  m_valid_q;
	res_t  res;
	res_t  res_q;
	logic  adv;
	logic  step;

	assign adv = !m_valid_q || m_tready;
	assign step = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	pis_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func         <= s_tuser[1:0];
			item_s1.igniter_sel  <= s_tuser[2];
			item_s1.drogue_sense <= $signed(s_tdata[15:0]);
			item_s1.main_sense   <= $signed(s_tdata[31:16]);
		end
	end

	pis_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, res_q.busy_res, res_q.main_status, res_q.drogue_status,
		res_q.main_out, res_q.drogue_out};

	`PIS_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_valid_q, s_tready, "input stalled with empty result register")
	`PIS_ASSERT_IMPL(a_pin_needs_busy, clk, arst_n, m_valid_q && (res_q.drogue_out || res_q.main_out), res_q.busy_res, "pin driven while idle")
	`PIS_ASSERT_IMPL(a_idle_not_active, clk, arst_n, m_valid_q && !res_q.busy_res, res_q.drogue_status != ST_ACTIVE && res_q.main_status != ST_ACTIVE, "channel active while idle")
	`PIS_ASSERT_NEXT(a_stage_held, clk, arst_n, valid_s1 && !adv, valid_s1, "input stage lost an item")

endmodule
